>>> hdl/i2cms_pkg.sv
// shared types and constants for the i2c master interrupt sequencer
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package i2cms_pkg;

  localparam int LEN_BITS = 16;
  localparam int NSLOT    = 4;   // result slots per word; a word raises at most three
  localparam int CNT_BITS = $clog2(NSLOT + 1);
  localparam int IDX_BITS = $clog2(NSLOT);

  typedef logic [LEN_BITS-1:0] len_t;
  typedef logic [CNT_BITS-1:0] cnt_t;
  typedef logic [IDX_BITS-1:0] idx_t;

  typedef enum logic [1:0] {
    MODE_READY = 2'd0,
    MODE_TX    = 2'd1,
    MODE_RX    = 2'd2
  } mode_t;

  localparam logic [2:0] KIND_START    = 3'd0;
  localparam logic [2:0] KIND_DR_WRITE = 3'd1;
  localparam logic [2:0] KIND_RX_BYTE  = 3'd2;
  localparam logic [2:0] KIND_TX_DONE  = 3'd3;
  localparam logic [2:0] KIND_STOPF    = 3'd4;

  localparam logic FUNC_START = 1'b0;

  localparam int FLAG_SB    = 0;
  localparam int FLAG_BTF   = 2;
  localparam int FLAG_STOPF = 3;
  localparam int FLAG_TXE   = 4;
  localparam int FLAG_RXNE  = 5;
  localparam int FLAG_MSL   = 6;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic [1:0] prior_state;
    logic       generate_start;
    logic       generate_stop;
    logic       clear_ack;
    logic       set_ack;
    logic       rx_done;
  } result_t;

  typedef struct packed {
    result_t [NSLOT-1:0] slot;
    cnt_t                cnt;
  } group_t;

endpackage

>>> hdl/i2cms_core.sv
// transfer state registers and single-pass word decode into a result group
// depends on i2cms_pkg
`timescale 1ns / 1ps

module i2cms_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic                  cfg_write,
  input  logic                  cfg_data,
  input  logic                  func,
  input  logic                  dir,
  input  logic [6:0]            slave_addr,
  input  logic [15:0]           length,
  input  logic                  repeated_start,
  input  logic [6:0]            status_flags,
  input  logic [7:0]            tx_byte,
  input  logic [7:0]            rx_byte,
  output i2cms_pkg::group_t     grp
);

  i2cms_pkg::mode_t transfer_mode, transfer_mode_next;
  logic [6:0]       target_address, target_address_next;
  i2cms_pkg::len_t  bytes_left, bytes_left_next;
  i2cms_pkg::len_t  transfer_size, transfer_size_next;
  logic             hold_bus, hold_bus_next;
  logic             events_enabled, events_enabled_next;
  logic             ack_enable;

  i2cms_pkg::result_t [i2cms_pkg::NSLOT-1:0] cand;
  logic [i2cms_pkg::NSLOT-1:0]               cand_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      transfer_mode  <= i2cms_pkg::MODE_READY;
      target_address <= '0;
      bytes_left     <= '0;
      transfer_size  <= '0;
      hold_bus       <= 1'b0;
      events_enabled <= 1'b0;
      ack_enable     <= 1'b1;
    end else begin
      if (accept) begin
        transfer_mode  <= transfer_mode_next;
        target_address <= target_address_next;
        bytes_left     <= bytes_left_next;
        transfer_size  <= transfer_size_next;
        hold_bus       <= hold_bus_next;
        events_enabled <= events_enabled_next;
      end
      if (cfg_write) begin
        ack_enable <= cfg_data;
      end
    end
  end

  always_comb begin
    logic            idle;
    logic            master;
    logic            got;
    logic            clr;
    i2cms_pkg::len_t bl_rx;
    i2cms_pkg::cnt_t n;

    transfer_mode_next  = transfer_mode;
    target_address_next = target_address;
    bytes_left_next     = bytes_left;
    transfer_size_next  = transfer_size;
    hold_bus_next       = hold_bus;
    events_enabled_next = events_enabled;
    cand   = '0;
    cand_v = '0;
    idle   = (transfer_mode != i2cms_pkg::MODE_TX) && (transfer_mode != i2cms_pkg::MODE_RX);
    master = status_flags[i2cms_pkg::FLAG_MSL];
    got    = (transfer_size != '0);
    clr    = (transfer_size > i2cms_pkg::len_t'(1)) && (bytes_left == i2cms_pkg::len_t'(2));
    bl_rx  = (got && bytes_left != '0) ? bytes_left - i2cms_pkg::len_t'(1) : bytes_left;

    if (func == i2cms_pkg::FUNC_START) begin
      cand_v[0]              = 1'b1;
      cand[0].kind           = i2cms_pkg::KIND_START;
      cand[0].prior_state    = transfer_mode;
      cand[0].generate_start = idle;
      if (idle) begin
        transfer_mode_next  = dir ? i2cms_pkg::MODE_RX : i2cms_pkg::MODE_TX;
        target_address_next = slave_addr;
        bytes_left_next     = i2cms_pkg::len_t'(length);
        if (dir) begin
          transfer_size_next = i2cms_pkg::len_t'(length);
        end
        hold_bus_next       = repeated_start;
        events_enabled_next = 1'b1;
      end
    end else if (events_enabled) begin
      // address byte with r/w bit
      if (status_flags[i2cms_pkg::FLAG_SB] && !idle) begin
        cand_v[0]         = 1'b1;
        cand[0].kind      = i2cms_pkg::KIND_DR_WRITE;
        cand[0].data_byte = {target_address, transfer_mode == i2cms_pkg::MODE_RX};
      end
      // btf closes a write only with txe set and nothing left
      if (status_flags[i2cms_pkg::FLAG_BTF] && status_flags[i2cms_pkg::FLAG_TXE] &&
          transfer_mode == i2cms_pkg::MODE_TX && bytes_left == '0) begin
        cand_v[1]             = 1'b1;
        cand[1].kind          = i2cms_pkg::KIND_TX_DONE;
        cand[1].generate_stop = !hold_bus;
        transfer_mode_next    = i2cms_pkg::MODE_READY;
        bytes_left_next       = '0;
        events_enabled_next   = 1'b0;
      end
      if (status_flags[i2cms_pkg::FLAG_STOPF]) begin
        cand_v[2]    = 1'b1;
        cand[2].kind = i2cms_pkg::KIND_STOPF;
      end
      // tx needs bytes left, so it never meets the btf close
      if (status_flags[i2cms_pkg::FLAG_TXE] && master &&
          transfer_mode == i2cms_pkg::MODE_TX && bytes_left != '0) begin
        cand_v[3]         = 1'b1;
        cand[3].kind      = i2cms_pkg::KIND_DR_WRITE;
        cand[3].data_byte = tx_byte;
        bytes_left_next   = bytes_left - i2cms_pkg::len_t'(1);
      end
      if (status_flags[i2cms_pkg::FLAG_RXNE] && master &&
          transfer_mode == i2cms_pkg::MODE_RX) begin
        bytes_left_next = bl_rx;
        if (bl_rx == '0) begin
          cand_v[3]             = 1'b1;
          cand[3].kind          = i2cms_pkg::KIND_RX_BYTE;
          cand[3].data_byte     = got ? rx_byte : 8'd0;
          cand[3].generate_stop = !hold_bus;
          cand[3].clear_ack     = clr;
          cand[3].set_ack       = ack_enable;
          cand[3].rx_done       = 1'b1;
          transfer_mode_next    = i2cms_pkg::MODE_READY;
          transfer_size_next    = '0;
          events_enabled_next   = 1'b0;
        end else if (got) begin
          cand_v[3]         = 1'b1;
          cand[3].kind      = i2cms_pkg::KIND_RX_BYTE;
          cand[3].data_byte = rx_byte;
          cand[3].clear_ack = clr;
        end
      end
    end

    // pack the raised results in handler order
    n   = '0;
    grp = '0;
    for (int i = 0; i < i2cms_pkg::NSLOT; i++) begin
      if (cand_v[i]) begin
        grp.slot[n[i2cms_pkg::IDX_BITS-1:0]] = cand[i];
        n = n + i2cms_pkg::cnt_t'(1);
      end
    end
    grp.cnt = n;
  end

endmodule

>>> hdl/i2cms_out.sv
// result group register and output serialiser, one word per cycle while out_ready is high
// depends on i2cms_pkg
`timescale 1ns / 1ps

module i2cms_out (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  i2cms_pkg::group_t  grp,
  output logic               can_load,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         kind,
  output logic [7:0]         data_byte,
  output logic [1:0]         prior_state,
  output logic               generate_start,
  output logic               generate_stop,
  output logic               clear_ack,
  output logic               set_ack,
  output logic               rx_done,
  output logic               last
);

  i2cms_pkg::group_t  held;
  logic               held_valid, held_valid_next;
  i2cms_pkg::idx_t    idx, idx_next;
  i2cms_pkg::result_t cur;
  logic               take;

  assign cur       = held.slot[idx];
  assign last      = ({1'b0, idx} == held.cnt - i2cms_pkg::cnt_t'(1));
  assign out_valid = held_valid;
  assign take      = held_valid && out_ready;
  // the group register frees as its final word leaves
  assign can_load  = !held_valid || (take && last);

  assign kind           = cur.kind;
  assign data_byte      = cur.data_byte;
  assign prior_state    = cur.prior_state;
  assign generate_start = cur.generate_start;
  assign generate_stop  = cur.generate_stop;
  assign clear_ack      = cur.clear_ack;
  assign set_ack        = cur.set_ack;
  assign rx_done        = cur.rx_done;

  always_comb begin
    held_valid_next = held_valid;
    idx_next        = idx;
    if (take) begin
      if (last) begin
        held_valid_next = 1'b0;
        idx_next        = '0;
      end else begin
        idx_next = idx + i2cms_pkg::idx_t'(1);
      end
    end
    if (load) begin
      held_valid_next = 1'b1;
      idx_next        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      idx        <= '0;
    end else begin
      held_valid <= held_valid_next;
      idx        <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= grp;
    end
  end

endmodule

>>> hdl/i2c_master_interrupt_sequencer.sv
// channel    | handshake            | payload
// in         | in_valid / in_ready  | func dir slave_addr length repeated_start
//            |                      | status_flags tx_byte rx_byte
// out        | out_valid / out_ready| kind data_byte prior_state generate_start
//            |                      | generate_stop clear_ack set_ack rx_done last
// cfg        | cfg_valid / cfg_ready| cfg_data (ack_enable)
//
// a word is decoded in the cycle it is accepted; its results appear from the next cycle
// one word per cycle while each raises at most one result and out_ready holds; a word
// with several results keeps the input stalled while the output serialiser drains them
// a word raising no result loads nothing; cfg writes are taken every cycle
// synchronous reset returns to ready with events disabled and ack_enable set
// top level: depends on i2cms_pkg, i2cms_core, i2cms_out
`timescale 1ns / 1ps

module i2c_master_interrupt_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic        dir,
  input  logic [6:0]  slave_addr,
  input  logic [15:0] length,
  input  logic        repeated_start,
  input  logic [6:0]  status_flags,
  input  logic [7:0]  tx_byte,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [7:0]  data_byte,
  output logic [1:0]  prior_state,
  output logic        generate_start,
  output logic        generate_stop,
  output logic        clear_ack,
  output logic        set_ack,
  output logic        rx_done,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  i2cms_pkg::group_t grp;
  logic              accept;
  logic              can_load;

  assign in_ready  = can_load;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  i2cms_core u_core (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .cfg_write      (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .func           (func),
    .dir            (dir),
    .slave_addr     (slave_addr),
    .length         (length),
    .repeated_start (repeated_start),
    .status_flags   (status_flags),
    .tx_byte        (tx_byte),
    .rx_byte        (rx_byte),
    .grp            (grp)
  );

  i2cms_out u_out (
    .clk            (clk),
    .rst            (rst),
    .load           (accept && grp.cnt != '0),
    .grp            (grp),
    .can_load       (can_load),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .data_byte      (data_byte),
    .prior_state    (prior_state),
    .generate_start (generate_start),
    .generate_stop  (generate_stop),
    .clear_ack      (clear_ack),
    .set_ack        (set_ack),
    .rx_done        (rx_done),
    .last           (last)
  );

endmodule

>>> hdl/i2cms_checker.sv
// port-level checks for the i2c master interrupt sequencer, bound to the top level
// depends on i2cms_pkg and i2c_master_interrupt_sequencer
`timescale 1ns / 1ps

module i2cms_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  kind,
  input logic [7:0]  data_byte,
  input logic        generate_start,
  input logic        rx_done,
  input logic        last
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(data_byte)
      && $stable(last))
    else $error("output word changed while stalled");

  // a start reply is always the only result of its word
  a_start_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == i2cms_pkg::KIND_START |-> last)
    else $error("start reply not marked last");

  a_start_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && generate_start |-> kind == i2cms_pkg::KIND_START)
    else $error("start requested outside a start reply");

  a_done_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && rx_done |-> kind == i2cms_pkg::KIND_RX_BYTE && last)
    else $error("receive close on wrong word");

  // input stays blocked while a word of a multi-result group is pending
  a_in_block: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("input taken while results still pending");

endmodule

bind i2c_master_interrupt_sequencer i2cms_checker u_chk (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .kind           (kind),
  .data_byte      (data_byte),
  .generate_start (generate_start),
  .rx_done        (rx_done),
  .last           (last)
);
